### src/api_pkg.sv
// ----------------------------------------------------------------------------
// api_pkg: shared types, codes and microprogram for the admittance proxy
// integrator.
// Holds the control word layout, the selector codes and the read-only
// program table that sequences the shared multiplier and adder.
// ----------------------------------------------------------------------------
`default_nettype none

package api_pkg;

    localparam int QW = 32;                        // Q16.16 word width
    localparam int DTW = 16;                       // Q0.16 time step width
    localparam int PCW = 4;                        // step counter width
    localparam int CFG_IDX_W = 2;                  // register index width

    localparam logic signed [QW-1:0] Q_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [QW-1:0] Q_MIN = 32'sh8000_0000;

    // Register indexes of the configuration port.
    localparam logic [CFG_IDX_W-1:0] REG_INV_MASS  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DAMPING   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_STIFFNESS = 2'd2;

    localparam logic [QW-1:0] RESET_INV_MASS = 32'h0001_0000;

    // Adder operand A.
    localparam logic [2:0] A_VEL = 3'd0;
    localparam logic [2:0] A_POS = 3'd1;
    localparam logic [2:0] A_TQ  = 3'd2;
    localparam logic [2:0] A_M   = 3'd3;
    localparam logic [2:0] A_SUM = 3'd4;

    // Adder operand B.
    localparam logic [1:0] B_DV = 2'd0;
    localparam logic [1:0] B_DP = 2'd1;
    localparam logic [1:0] B_M  = 2'd2;
    localparam logic [1:0] B_DA = 2'd3;

    // Adder destination.
    localparam logic [2:0] D_EV  = 3'd0;
    localparam logic [2:0] D_EQ  = 3'd1;
    localparam logic [2:0] D_SUM = 3'd2;           // wide, not saturated
    localparam logic [2:0] D_F   = 3'd3;
    localparam logic [2:0] D_ACC = 3'd4;
    localparam logic [2:0] D_VEL = 3'd5;
    localparam logic [2:0] D_POS = 3'd6;

    // Multiplier unsigned factor.
    localparam logic [1:0] F_DAMP  = 2'd0;
    localparam logic [1:0] F_STIFF = 2'd1;
    localparam logic [1:0] F_INVM  = 2'd2;
    localparam logic [1:0] F_DT    = 2'd3;

    // Multiplier signed operand.
    localparam logic [2:0] S_EV  = 3'd0;
    localparam logic [2:0] S_EQ  = 3'd1;
    localparam logic [2:0] S_F   = 3'd2;
    localparam logic [2:0] S_ACC = 3'd3;
    localparam logic [2:0] S_VEL = 3'd4;

    // Sequencing conditions.
    localparam logic [1:0] JC_NEXT     = 2'd0;
    localparam logic [1:0] JC_JUMP     = 2'd1;
    localparam logic [1:0] JC_WAIT_IN  = 2'd2;    // hold until an item arrives
    localparam logic [1:0] JC_WAIT_OUT = 2'd3;    // hold while output is full

    // Program steps.
    localparam logic [PCW-1:0] ST_IDLE    = 4'd0;
    localparam logic [PCW-1:0] ST_EV      = 4'd1;
    localparam logic [PCW-1:0] ST_EQ      = 4'd2;
    localparam logic [PCW-1:0] ST_MSTIFF  = 4'd3;
    localparam logic [PCW-1:0] ST_SUM     = 4'd4;
    localparam logic [PCW-1:0] ST_FORCE   = 4'd5;
    localparam logic [PCW-1:0] ST_MINVM   = 4'd6;
    localparam logic [PCW-1:0] ST_RINVM   = 4'd7;
    localparam logic [PCW-1:0] ST_ACC     = 4'd8;
    localparam logic [PCW-1:0] ST_MDTA    = 4'd9;
    localparam logic [PCW-1:0] ST_RDTA    = 4'd10;
    localparam logic [PCW-1:0] ST_VEL     = 4'd11;
    localparam logic [PCW-1:0] ST_MDTV    = 4'd12;
    localparam logic [PCW-1:0] ST_RDTV    = 4'd13;
    localparam logic [PCW-1:0] ST_POS     = 4'd14;
    localparam logic [PCW-1:0] ST_EMIT    = 4'd15;

    typedef struct packed {
        logic           alu_en;
        logic [2:0]     alu_a;
        logic [1:0]     alu_b;
        logic           alu_sub;
        logic [2:0]     alu_dst;
        logic           mul_en;
        logic [1:0]     mul_f;
        logic [2:0]     mul_s;
        logic           rnd_en;
        logic [1:0]     jcond;
        logic [PCW-1:0] jtgt;
    } t_ctl;

    function automatic t_ctl ucode(input logic [PCW-1:0] pc);
        t_ctl c;
        c = '0;
        unique case (pc)
            ST_IDLE: begin
                c.jcond = JC_WAIT_IN;
            end
            ST_EV: begin
                c.alu_en = 1'b1; c.alu_a = A_VEL; c.alu_b = B_DV;
                c.alu_sub = 1'b1; c.alu_dst = D_EV;
            end
            ST_EQ: begin
                c.alu_en = 1'b1; c.alu_a = A_POS; c.alu_b = B_DP;
                c.alu_sub = 1'b1; c.alu_dst = D_EQ;
                c.mul_en = 1'b1; c.mul_f = F_DAMP; c.mul_s = S_EV;
            end
            ST_MSTIFF: begin
                c.rnd_en = 1'b1;
                c.mul_en = 1'b1; c.mul_f = F_STIFF; c.mul_s = S_EQ;
            end
            ST_SUM: begin
                c.alu_en = 1'b1; c.alu_a = A_TQ; c.alu_b = B_M;
                c.alu_sub = 1'b1; c.alu_dst = D_SUM;
                c.rnd_en = 1'b1;
            end
            ST_FORCE: begin
                c.alu_en = 1'b1; c.alu_a = A_SUM; c.alu_b = B_M;
                c.alu_sub = 1'b1; c.alu_dst = D_F;
            end
            ST_MINVM: begin
                c.mul_en = 1'b1; c.mul_f = F_INVM; c.mul_s = S_F;
            end
            ST_RINVM: begin
                c.rnd_en = 1'b1;
            end
            ST_ACC: begin
                c.alu_en = 1'b1; c.alu_a = A_M; c.alu_b = B_DA;
                c.alu_dst = D_ACC;
            end
            ST_MDTA: begin
                c.mul_en = 1'b1; c.mul_f = F_DT; c.mul_s = S_ACC;
            end
            ST_RDTA: begin
                c.rnd_en = 1'b1;
            end
            ST_VEL: begin
                c.alu_en = 1'b1; c.alu_a = A_VEL; c.alu_b = B_M;
                c.alu_dst = D_VEL;
            end
            ST_MDTV: begin
                c.mul_en = 1'b1; c.mul_f = F_DT; c.mul_s = S_VEL;
            end
            ST_RDTV: begin
                c.rnd_en = 1'b1;
            end
            ST_POS: begin
                c.alu_en = 1'b1; c.alu_a = A_POS; c.alu_b = B_M;
                c.alu_dst = D_POS;
            end
            ST_EMIT: begin
                c.jcond = JC_WAIT_OUT; c.jtgt = ST_IDLE;
            end
            default: begin
                c.jcond = JC_JUMP; c.jtgt = ST_IDLE;
            end
        endcase
        return c;
    endfunction

endpackage

`default_nettype wire

### src/admittance_proxy_integrator.sv
// ----------------------------------------------------------------------------
// admittance_proxy_integrator: virtual mass-spring-damper proxy update.
// One control tick in, one updated proxy state out, in signed Q16.16 with
// saturation, sequenced by a small microprogram over one multiplier.
// ----------------------------------------------------------------------------
// Each accepted item is one control tick. The block forms the proxy
// acceleration inverse_mass * (-damping*(v - vd) - stiffness*(q - qd) + torque)
// + desired acceleration, then integrates velocity and, with the new velocity,
// position by semi-implicit Euler. On the first tick after reset the proxy
// position and velocity are taken from the measured values; afterwards the
// measurements are ignored. Every difference, product and sum, bar the partial
// force sum, is clipped to signed 32 bits and any clipping sets the saturated
// flag of that result. For each tick the microprogram runs fifteen steps
// after the accepting one, and the single 32 by 32 bit multiplier, with a
// rounding stage behind it, carries the five dependent products in turn.
// A finished result sits in the output register, so the next item is
// taken while it waits; only a second result held up by a stalled consumer
// halts the program at its final step. Configuration writes are taken in
// every cycle and should be made only while the block is idle; a write to
// an index beyond the three registers is ignored.
// ----------------------------------------------------------------------------
`default_nettype none

module admittance_proxy_integrator
    import api_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    // Configuration write channel.
    input  wire logic                 i_cfg_valid,
    output logic                      o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [QW-1:0]        i_cfg_data,
    // Input items. tdata from bit 0 up: measured_position, measured_velocity,
    // desired_position, desired_velocity, desired_acceleration,
    // external_torque (32 bits each), time_step (16 bits).
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    input  wire logic [6*QW+DTW-1:0]  s_tdata,
    // Result items. tdata from bit 0 up: proxy_position, proxy_velocity,
    // proxy_acceleration (32 bits each). tuser: saturated.
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    output logic [3*QW-1:0]           m_tdata,
    output logic [0:0]                m_tuser
);

    // Configuration registers.
    logic [QW-1:0] r_inv_mass, r_damping, r_stiffness;

    // Proxy state and sequencer.
    logic signed [QW-1:0] r_pos, r_vel, r_acc;
    logic                 r_started;
    logic [PCW-1:0]       r_pc, n_pc;

    // Tick operands latched at acceptance.
    logic signed [QW-1:0] r_dp, r_dv, r_da, r_tq;
    logic [DTW-1:0]       r_dt;

    // Working registers.
    logic signed [QW-1:0] r_ev, r_eq, r_f, r_m;
    logic signed [QW+2:0] r_sum;
    logic [2*QW-1:0]      r_prod;
    logic                 r_neg;
    logic                 r_sat;

    // Output register.
    logic                 r_m_tvalid;
    logic [3*QW-1:0]      r_m_tdata;
    logic                 r_m_tuser;

    t_ctl ctl;
    logic in_fire, out_blocked, emit_fire;

    assign ctl         = ucode(r_pc);
    assign s_tready    = (ctl.jcond == JC_WAIT_IN);
    assign in_fire     = s_tvalid && s_tready;
    assign out_blocked = r_m_tvalid && !m_tready;
    assign emit_fire   = (ctl.jcond == JC_WAIT_OUT) && !out_blocked;
    assign o_cfg_ready = 1'b1;

    // Sequencer: one control word per step, with held and jumped steps.
    always_comb begin
        unique case (ctl.jcond)
            JC_NEXT:     n_pc = r_pc + PCW'(1);
            JC_JUMP:     n_pc = ctl.jtgt;
            JC_WAIT_IN:  n_pc = in_fire ? r_pc + PCW'(1) : r_pc;
            JC_WAIT_OUT: n_pc = out_blocked ? r_pc : ctl.jtgt;
            default:     n_pc = ctl.jtgt;
        endcase
    end

    // Multiplier front end: unsigned factor times the magnitude of a signed
    // operand, the sign carried alongside the product.
    logic [QW-1:0]        mul_f, mul_mag;
    logic signed [QW-1:0] mul_s;

    always_comb begin
        unique case (ctl.mul_f)
            F_DAMP:  mul_f = r_damping;
            F_STIFF: mul_f = r_stiffness;
            F_INVM:  mul_f = r_inv_mass;
            F_DT:    mul_f = {{(QW-DTW){1'b0}}, r_dt};
            default: mul_f = r_damping;
        endcase
        unique case (ctl.mul_s)
            S_EV:    mul_s = r_ev;
            S_EQ:    mul_s = r_eq;
            S_F:     mul_s = r_f;
            S_ACC:   mul_s = r_acc;
            S_VEL:   mul_s = r_vel;
            default: mul_s = r_ev;
        endcase
        mul_mag = mul_s[QW-1] ? QW'(-mul_s) : QW'(mul_s);
    end

    // Rounding stage: shift right by 16 with ties away from zero, restore the
    // sign and clip to 32 bits.
    logic [2*QW-1:0]      rnd_sum;
    logic [2*QW-17:0]     rnd_mag;
    logic                 rnd_clip;
    logic signed [QW-1:0] rnd_val;

    always_comb begin
        rnd_sum = r_prod + 64'h0000_0000_0000_8000;
        rnd_mag = rnd_sum[2*QW-1:16];
        if (r_neg) begin
            rnd_clip = (rnd_mag > 48'h0000_8000_0000);
        end else begin
            rnd_clip = (rnd_mag > 48'h0000_7FFF_FFFF);
        end
        if (rnd_clip) begin
            rnd_val = r_neg ? Q_MIN : Q_MAX;
        end else if (r_neg) begin
            rnd_val = QW'(-rnd_mag[QW-1:0]);
        end else begin
            rnd_val = rnd_mag[QW-1:0];
        end
    end

    // Adder: exact sum in 35 bits, clipped unless it stays wide.
    logic signed [QW+2:0] alu_a, alu_b, alu_raw;
    logic                 alu_clip, alu_wide;
    logic signed [QW-1:0] alu_val;

    always_comb begin
        unique case (ctl.alu_a)
            A_VEL:   alu_a = {{3{r_vel[QW-1]}}, r_vel};
            A_POS:   alu_a = {{3{r_pos[QW-1]}}, r_pos};
            A_TQ:    alu_a = {{3{r_tq[QW-1]}}, r_tq};
            A_M:     alu_a = {{3{r_m[QW-1]}}, r_m};
            A_SUM:   alu_a = r_sum;
            default: alu_a = r_sum;
        endcase
        unique case (ctl.alu_b)
            B_DV:    alu_b = {{3{r_dv[QW-1]}}, r_dv};
            B_DP:    alu_b = {{3{r_dp[QW-1]}}, r_dp};
            B_M:     alu_b = {{3{r_m[QW-1]}}, r_m};
            B_DA:    alu_b = {{3{r_da[QW-1]}}, r_da};
            default: alu_b = {{3{r_m[QW-1]}}, r_m};
        endcase
        alu_raw  = ctl.alu_sub ? alu_a - alu_b : alu_a + alu_b;
        alu_wide = (ctl.alu_dst == D_SUM);
        if (alu_raw > 35'sh7FFF_FFFF) begin
            alu_clip = 1'b1;
            alu_val  = Q_MAX;
        end else if (alu_raw < -35'sh8000_0000) begin
            alu_clip = 1'b1;
            alu_val  = Q_MIN;
        end else begin
            alu_clip = 1'b0;
            alu_val  = alu_raw[QW-1:0];
        end
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc        <= ST_IDLE;
            r_started   <= 1'b0;
            r_m_tvalid  <= 1'b0;
            r_inv_mass  <= RESET_INV_MASS;
            r_damping   <= '0;
            r_stiffness <= '0;
            r_pos       <= '0;
            r_vel       <= '0;
            r_acc       <= '0;
        end else begin
            r_pc <= n_pc;
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    REG_INV_MASS:  r_inv_mass  <= i_cfg_data;
                    REG_DAMPING:   r_damping   <= i_cfg_data;
                    REG_STIFFNESS: r_stiffness <= i_cfg_data;
                    default: ;
                endcase
            end
            if (in_fire) begin
                r_started <= 1'b1;
                if (!r_started) begin
                    r_pos <= s_tdata[QW-1:0];
                    r_vel <= s_tdata[2*QW-1:QW];
                end
            end
            if (ctl.alu_en) begin
                unique case (ctl.alu_dst)
                    D_ACC:   r_acc <= alu_val;
                    D_VEL:   r_vel <= alu_val;
                    D_POS:   r_pos <= alu_val;
                    default: ;
                endcase
            end
            if (emit_fire) begin
                r_m_tvalid <= 1'b1;
            end else if (m_tready) begin
                r_m_tvalid <= 1'b0;
            end
        end
    end

    // Datapath payload.
    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_dp  <= s_tdata[3*QW-1:2*QW];
            r_dv  <= s_tdata[4*QW-1:3*QW];
            r_da  <= s_tdata[5*QW-1:4*QW];
            r_tq  <= s_tdata[6*QW-1:5*QW];
            r_dt  <= s_tdata[6*QW+DTW-1:6*QW];
            r_sat <= 1'b0;
        end else if ((ctl.alu_en && alu_clip && !alu_wide) || (ctl.rnd_en && rnd_clip)) begin
            r_sat <= 1'b1;
        end
        if (ctl.mul_en) begin
            r_prod <= (2*QW)'(mul_f) * (2*QW)'(mul_mag);
            r_neg  <= mul_s[QW-1];
        end
        if (ctl.rnd_en) begin
            r_m <= rnd_val;
        end
        if (ctl.alu_en) begin
            unique case (ctl.alu_dst)
                D_EV:    r_ev  <= alu_val;
                D_EQ:    r_eq  <= alu_val;
                D_SUM:   r_sum <= alu_raw;
                D_F:     r_f   <= alu_val;
                default: ;
            endcase
        end
        if (emit_fire) begin
            r_m_tdata <= {r_acc, r_vel, r_pos};
            r_m_tuser <= r_sat;
        end
    end

    assign m_tvalid   = r_m_tvalid;
    assign m_tdata    = r_m_tdata;
    assign m_tuser[0] = r_m_tuser;

    // An accepted item always starts the program at its first working step.
    a_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_fire |=> (r_pc == ST_EV))
        else $error("program did not start after an accepted item");

    // A new result appears only from the final step.
    a_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($rose(r_m_tvalid) && $past(i_rst_n)) |-> ($past(r_pc) == ST_EMIT))
        else $error("result raised outside the final step");

    // The program returns to the waiting step only from the final step.
    a_return: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_pc == ST_IDLE) && $past(i_rst_n) && ($past(r_pc) != ST_IDLE))
            |-> ($past(r_pc) == ST_EMIT))
        else $error("program left a tick unfinished");

    // Once the proxy is initialised it stays so until reset.
    a_started: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_started |=> r_started)
        else $error("proxy lost its initialised state");

endmodule

`default_nettype wire

### dv/admittance_proxy_integrator_tb.sv
// ----------------------------------------------------------------------------
// admittance_proxy_integrator_tb: self-checking bench for the proxy integrator.
// A short table of directed ticks and register writes is followed by eight
// phases of random ticks, each under its own damping, stiffness and inverse
// mass. A predictor mirrors the proxy state in 64-bit arithmetic with
// saturation and rounding. Every result item is compared field by field with
// the oldest prediction, while both stream sides idle and stall at random.
// ----------------------------------------------------------------------------

module admittance_proxy_integrator_tb;

    localparam int QW          = api_pkg::QW;
    localparam int DTW         = api_pkg::DTW;
    localparam int IW          = api_pkg::CFG_IDX_W;
    localparam int PLAN_LEN    = 24;
    localparam int PHASES      = 8;
    localparam int PHASE_TICKS = 240;
    // Quiet cycles waited after the last result; this is ample for the block
    // to settle back to idle.
    localparam int SETTLE_CYCLES = 24;
    localparam int CYCLE_LIMIT   = 500000;

    // The index just past the three registers. Writes to it must be ignored.
    localparam logic [IW-1:0] REG_UNUSED = 2'd3;

    typedef logic signed [QW-1:0] t_q;

    localparam t_q Q_ONE = 32'sh0001_0000;
    localparam t_q Q_HI  = api_pkg::Q_MAX;
    localparam t_q Q_LO  = api_pkg::Q_MIN;
    localparam longint SAT_HI = 64'sh0000_0000_7FFF_FFFF;
    localparam longint SAT_LO = -64'sh0000_0000_8000_0000;

    // One control tick, in the order in which the fields sit in s_tdata.
    typedef struct {
        t_q             mp;     // measured position
        t_q             mv;     // measured velocity
        t_q             dp;     // desired position
        t_q             dv;     // desired velocity
        t_q             da;     // desired acceleration
        t_q             tq;     // external torque
        logic [DTW-1:0] dt;     // tick period, Q0.16
    } t_tick;

    // One updated proxy state as it leaves the block.
    typedef struct {
        logic [QW-1:0] pos;
        logic [QW-1:0] vel;
        logic [QW-1:0] acc;
        logic          sat;
    } t_proxy;

    typedef enum bit { ROW_TICK, ROW_WRITE } t_row_kind;

    typedef struct {
        t_row_kind     kind;
        t_tick         tick;
        bit            known;      // the result is typed into the row
        t_proxy        want;
        logic [IW-1:0] reg_index;
        logic [QW-1:0] reg_value;
    } t_row;

    // ------------------------------------------------------------------------
    // Clock, reset and the signals around the block. Every input starts at a
    // known value.
    // ------------------------------------------------------------------------
    logic                i_clk       = 1'b0;
    logic                i_rst_n     = 1'b0;
    logic                i_cfg_valid = 1'b0;
    logic [IW-1:0]       i_cfg_index = '0;
    logic [QW-1:0]       i_cfg_data  = '0;
    logic                s_tvalid    = 1'b0;
    logic [6*QW+DTW-1:0] s_tdata     = '0;
    logic                m_tready    = 1'b0;
    logic                o_cfg_ready;
    logic                s_tready;
    logic                m_tvalid;
    logic [3*QW-1:0]     m_tdata;
    logic [0:0]          m_tuser;

    always #10 i_clk = ~i_clk;

    admittance_proxy_integrator dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser)
    );

    // ------------------------------------------------------------------------
    // Predictor. It keeps its own copy of the registers and of the proxy
    // state, and works in 64 bits so that every difference, product and sum
    // is exact before it is clipped to signed 32 bits.
    // ------------------------------------------------------------------------
    logic [QW-1:0] inv_mass_q  = 32'h0001_0000;
    logic [QW-1:0] damping_q   = '0;
    logic [QW-1:0] stiffness_q = '0;
    longint        proxy_pos   = 0;
    longint        proxy_vel   = 0;
    longint        proxy_acc   = 0;
    bit            proxy_live  = 1'b0;     // set by the first tick after reset
    bit            clip_seen;

    t_proxy proxy_updates_due[$];
    int     error_count = 0;
    int     cycle_count = 0;
    bit     steady [2] = '{1'b0, 1'b0};    // per side: a stretch without idling
    t_row   plan [PLAN_LEN];

    function automatic longint clip32(input longint x);
        if (x > SAT_HI) begin
            clip_seen = 1'b1;
            return SAT_HI;
        end
        if (x < SAT_LO) begin
            clip_seen = 1'b1;
            return SAT_LO;
        end
        return x;
    endfunction

    // Unsigned factor times signed Q16.16. The magnitude is rounded to
    // nearest, so ties go away from zero once the sign is put back.
    function automatic longint scale_q(input logic [QW-1:0] f, input longint s);
        bit          neg;
        logic [63:0] mag;
        logic [63:0] prod;
        longint      v;
        neg  = s < 0;
        mag  = neg ? 64'(-s) : 64'(s);
        prod = {32'h0, f} * mag;
        v    = longint'((prod + 64'h8000) >> 16);
        return clip32(neg ? -v : v);
    endfunction

    function automatic t_proxy advance_proxy(input t_tick t);
        t_proxy r;
        longint vel_err;
        longint pos_err;
        longint force_sum;
        clip_seen = 1'b0;
        // The measurements seed the proxy once and are ignored from then on.
        if (!proxy_live) begin
            proxy_live = 1'b1;
            proxy_pos  = longint'(t.mp);
            proxy_vel  = longint'(t.mv);
        end
        vel_err   = clip32(proxy_vel - longint'(t.dv));
        pos_err   = clip32(proxy_pos - longint'(t.dp));
        // The force is clipped once, after all three terms are summed.
        force_sum = clip32(-scale_q(damping_q, vel_err) - scale_q(stiffness_q, pos_err)
                           + longint'(t.tq));
        proxy_acc = clip32(scale_q(inv_mass_q, force_sum) + longint'(t.da));
        // Semi-implicit Euler: position moves with the new velocity.
        proxy_vel = clip32(proxy_vel + scale_q({16'h0, t.dt}, proxy_acc));
        proxy_pos = clip32(proxy_pos + scale_q({16'h0, t.dt}, proxy_vel));
        r.pos = proxy_pos[QW-1:0];
        r.vel = proxy_vel[QW-1:0];
        r.acc = proxy_acc[QW-1:0];
        r.sat = clip_seen;
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // Stimulus helpers.
    // ------------------------------------------------------------------------
    function automatic t_row tick_row(input t_q mp, input t_q mv, input t_q dp,
                                      input t_q dv, input t_q da, input t_q tq,
                                      input logic [DTW-1:0] dt, input bit known = 1'b0,
                                      input t_q epos = '0, input t_q evel = '0,
                                      input t_q eacc = '0, input bit esat = 1'b0);
        t_row r;
        r = '{kind: ROW_TICK, default: '0};
        r.kind  = ROW_TICK;
        r.tick  = '{mp, mv, dp, dv, da, tq, dt};
        r.known = known;
        r.want  = '{epos, evel, eacc, esat};
        return r;
    endfunction

    function automatic t_row write_row(input logic [IW-1:0] idx, input logic [QW-1:0] val);
        t_row r;
        r = '{kind: ROW_WRITE, default: '0};
        r.kind      = ROW_WRITE;
        r.reg_index = idx;
        r.reg_value = val;
        return r;
    endfunction

    // Idle cycles before the next item on one side. Now and then a side
    // switches into or out of a stretch where it never idles.
    function automatic int draw_wait(input int side);
        if ($urandom_range(0, 39) == 0)
            steady[side] = !steady[side];
        return steady[side] ? 0 : $urandom_range(0, 10);
    endfunction

    // Calm values stay within about sixteen units, so that the proxy state
    // evolves rather than pinning at the rails; the rest reach every bit.
    function automatic t_q pick_q(input bit calm);
        if (calm)
            return $urandom_range(0, 32'h0020_0000) - 32'h0010_0000;
        case ($urandom_range(0, 5))
            0: return Q_HI;
            1: return Q_LO;
            2: return '0;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [DTW-1:0] pick_dt(input bit calm);
        if (calm)
            return ($urandom_range(0, 15) == 0) ? '0 : DTW'($urandom_range(1, 16'h0400));
        case ($urandom_range(0, 3))
            0: return '0;
            1: return 16'hFFFF;
            default: return DTW'($urandom);
        endcase
    endfunction

    function automatic logic [QW-1:0] pick_coef();
        case ($urandom_range(0, 5))
            0: return '0;
            1: return 32'hFFFF_FFFF;
            2: return $urandom;
            default: return $urandom_range(0, 32'h0004_0000);
        endcase
    endfunction

    // Offers one tick and, once the block takes it, files the prediction.
    // The valid is lowered only when an idle gap follows, so that it is never
    // dropped and raised again in the same time step.
    task automatic drive_tick(input t_tick t, input bit known, input t_proxy want);
        int     gap;
        t_proxy due;
        gap = draw_wait(0);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {t.dt, t.tq, t.da, t.dv, t.dp, t.mv, t.mp};
        @(posedge i_clk);
        while (!s_tready) @(posedge i_clk);
        due = advance_proxy(t);
        if (known)
            due = want;
        proxy_updates_due.push_back(due);
    endtask

    // Writes one register. The valid stays high for back-to-back writes; the
    // caller lowers it after the last one.
    task automatic write_reg(input logic [IW-1:0] idx, input logic [QW-1:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        case (idx)
            api_pkg::REG_INV_MASS:  inv_mass_q  = val;
            api_pkg::REG_DAMPING:   damping_q   = val;
            api_pkg::REG_STIFFNESS: stiffness_q = val;
            default: ;
        endcase
    endtask

    // Stops offering ticks and waits until every predicted result is back
    // and the block has had time to fall idle.
    task automatic drain_ticks();
        s_tvalid <= 1'b0;
        while (proxy_updates_due.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // ------------------------------------------------------------------------
    // Main sequence: reset, the directed table, then the random phases.
    // ------------------------------------------------------------------------
    initial begin
        int             i;
        int             ph;
        int             n;
        bit             calm;
        t_tick          t;
        t_proxy         no_want;
        logic [QW-1:0]  coef [3];

        no_want = '{default: '0};
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // The first four rows run on the reset register values, so their
        // results can be read straight off the equations. The first tick
        // seeds the proxy from the measurements, the second shows that later
        // measurements are ignored, and the next two drive the acceleration
        // into both rails with a zero tick period holding the proxy still.
        plan = '{
            tick_row(Q_ONE, '0, Q_ONE, '0, '0, '0, '0,
                     1'b1, Q_ONE, '0, '0, 1'b0),
            tick_row(32'sh0005_0000, 32'sh0003_0000, Q_ONE, '0, '0, Q_ONE, '0,
                     1'b1, Q_ONE, '0, Q_ONE, 1'b0),
            tick_row(Q_LO, Q_HI, Q_ONE, '0, Q_HI, Q_HI, '0,
                     1'b1, Q_ONE, '0, Q_HI, 1'b1),
            tick_row(Q_HI, Q_LO, Q_ONE, '0, Q_LO, Q_LO, '0,
                     1'b1, Q_ONE, '0, Q_LO, 1'b1),
            // Longest tick period, then the velocity and position rails.
            tick_row('0, '0, '0, '0, '0, Q_ONE, 16'hFFFF),
            tick_row('0, '0, '0, '0, Q_HI, Q_HI, 16'hFFFF),
            tick_row('0, '0, '0, '0, Q_LO, Q_LO, 16'hFFFF),
            tick_row('0, '0, Q_HI, Q_LO, '0, '0, 16'h0041),
            // Full-scale damping and stiffness push the force products past
            // the rails.
            write_row(api_pkg::REG_DAMPING, 32'hFFFF_FFFF),
            tick_row('0, '0, '0, Q_HI, '0, '0, 16'h0100),
            write_row(api_pkg::REG_STIFFNESS, 32'hFFFF_FFFF),
            tick_row('0, '0, Q_LO, Q_LO, '0, '0, '0),
            tick_row('0, '0, Q_ONE, -Q_ONE, Q_ONE, -Q_ONE, 16'h0001),
            // With no inverse mass the acceleration is the desired one.
            write_row(api_pkg::REG_INV_MASS, '0),
            tick_row('0, '0, '0, '0, 32'sh1234_5678, Q_HI, '0),
            tick_row('0, '0, '0, '0, -Q_ONE, Q_LO, 16'hFFFF),
            // A write past the last register leaves everything as it was.
            write_row(REG_UNUSED, 32'hDEAD_BEEF),
            tick_row('0, '0, Q_ONE, '0, 32'sh0000_8000, '0, 16'h8000),
            write_row(api_pkg::REG_INV_MASS, 32'hFFFF_FFFF),
            write_row(api_pkg::REG_DAMPING, 32'h0000_8000),
            write_row(api_pkg::REG_STIFFNESS, 32'h0002_0000),
            tick_row('0, '0, 32'sh0000_0003, -32'sh0000_0001, '0, 32'sh0000_0001, 16'h0001),
            tick_row('0, '0, -32'sh0000_0003, 32'sh0000_0005, '0, -32'sh0000_0001, 16'h0200),
            tick_row(Q_HI, Q_LO, '0, '0, '0, '0, 16'hFFFF)
        };

        for (i = 0; i < PLAN_LEN; i++) begin
            if (plan[i].kind == ROW_WRITE) begin
                drain_ticks();
                write_reg(plan[i].reg_index, plan[i].reg_value);
                i_cfg_valid <= 1'b0;
            end else begin
                drive_tick(plan[i].tick, plan[i].known, plan[i].want);
            end
        end

        // Each random phase starts from an idle block with fresh coefficients:
        // all at full scale, all zero, a gentle unit setting, then draws.
        for (ph = 0; ph < PHASES; ph++) begin
            drain_ticks();
            case (ph)
                0: coef = '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF};
                1: coef = '{32'h0, 32'h0, 32'h0};
                2: coef = '{32'h0001_0000, 32'h0000_8000, 32'h0002_0000};
                default: coef = '{pick_coef(), pick_coef(), pick_coef()};
            endcase
            write_reg(api_pkg::REG_INV_MASS, coef[0]);
            write_reg(api_pkg::REG_DAMPING, coef[1]);
            write_reg(api_pkg::REG_STIFFNESS, coef[2]);
            write_reg(REG_UNUSED, $urandom);
            i_cfg_valid <= 1'b0;

            for (n = 0; n < PHASE_TICKS; n++) begin
                // Most ticks are calm so the proxy keeps moving; the rest
                // throw extremes and raw bit patterns at it.
                calm = $urandom_range(0, 9) < 7;
                t.mp = $urandom;
                t.mv = $urandom;
                t.dp = pick_q(calm);
                t.dv = pick_q(calm);
                t.da = pick_q(calm);
                t.tq = pick_q(calm);
                t.dt = pick_dt(calm);
                drive_tick(t, 1'b0, no_want);
            end
        end

        drain_ticks();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (error_count == 0)
            $display("admittance_proxy_integrator_tb: PASS");
        else
            $display("admittance_proxy_integrator_tb: FAIL");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Result side. A stall is drawn per item; when non-zero, tready is held
    // low until a result is actually waiting and then until the drawn stall
    // has run out, so that a second finished tick backs up behind the first.
    // Nothing is sampled until reset has been released.
    // ------------------------------------------------------------------------
    initial begin
        int     stall;
        t_proxy got;
        t_proxy due;
        wait (i_rst_n === 1'b1);
        forever begin
            stall = draw_wait(1);
            if (stall > 0) begin
                m_tready <= 1'b0;
                @(posedge i_clk);
                while (!m_tvalid) @(posedge i_clk);
                repeat (stall - 1) @(posedge i_clk);
            end
            m_tready <= 1'b1;
            @(posedge i_clk);
            while (!m_tvalid) @(posedge i_clk);

            got.pos = m_tdata[QW-1:0];
            got.vel = m_tdata[2*QW-1:QW];
            got.acc = m_tdata[3*QW-1:2*QW];
            got.sat = m_tuser[0];
            if (proxy_updates_due.size() == 0) begin
                $error("result item with no tick outstanding: pos %h vel %h acc %h",
                       got.pos, got.vel, got.acc);
                error_count++;
            end else begin
                due = proxy_updates_due.pop_front();
                if (got.pos !== due.pos) begin
                    $error("proxy_position: expected %h, got %h", due.pos, got.pos);
                    error_count++;
                end
                if (got.vel !== due.vel) begin
                    $error("proxy_velocity: expected %h, got %h", due.vel, got.vel);
                    error_count++;
                end
                if (got.acc !== due.acc) begin
                    $error("proxy_acceleration: expected %h, got %h", due.acc, got.acc);
                    error_count++;
                end
                if (got.sat !== due.sat) begin
                    $error("saturated: expected %b, got %b", due.sat, got.sat);
                    error_count++;
                end
            end
        end
    end

    // A hung handshake ends the run here.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("admittance_proxy_integrator_tb: FAIL");
            $finish;
        end
    end

endmodule

### admittance_proxy_integrator.f
src/api_pkg.sv
src/admittance_proxy_integrator.sv
dv/admittance_proxy_integrator_tb.sv
